// File: sv/tfn_pkg.sv
`default_nettype none
package tfn_pkg;
    // Field and datapath widths.
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = 31;
    localparam int SHIFT_W     = 6;
    localparam int SHIFT_SPAN  = CROSS_W - MAG_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int FRAC_W      = 14;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int NUM_W       = MAG_W + FRAC_W + 1;
    localparam int DEN_W       = ROOT_W;
    localparam int DREM_W      = DEN_W + 1;
    localparam int OUT_W       = 16;
    localparam int LEN_W       = 16;
    localparam int FLOOR_SHIFT = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd66;
    localparam logic [QUO_W-1:0] Q_CAP     = QUO_W'(1) << FRAC_W;

    // Values that ride alongside the square root.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [DEN_W-1:0]      floor_val;
    } side_t;
endpackage
`default_nettype wire

// File: sv/tfn_sqrt.sv
`default_nettype none
module tfn_sqrt (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [tfn_pkg::SUM_W-1:0]      radicand,
    output logic      [tfn_pkg::ROOT_W-1:0]     root
);
    localparam int N = tfn_pkg::ROOT_W;

    logic [tfn_pkg::SUM_W-1:0]  rad_reg  [0:N-1];
    logic [tfn_pkg::REM_W-1:0]  rem_reg  [0:N-1];
    logic [tfn_pkg::ROOT_W-1:0] root_reg [0:N-1];

    // One result bit per stage, two radicand bits consumed per stage.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [tfn_pkg::SUM_W-1:0]  rad_src;
        logic [tfn_pkg::REM_W-1:0]  rem_src;
        logic [tfn_pkg::ROOT_W-1:0] root_src;
        logic [tfn_pkg::REM_W-1:0]  rem_sh;
        logic [tfn_pkg::REM_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign rad_src  = radicand;
            assign rem_src  = '0;
            assign root_src = '0;
        end else begin : g_rest
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
        end

        assign rem_sh = {rem_src[tfn_pkg::REM_W-3:0], rad_src[tfn_pkg::SUM_W-1 -: 2]};
        assign trial  = {1'b0, root_src, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= {rad_src[tfn_pkg::SUM_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_src[tfn_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_src[tfn_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[N-1];
endmodule
`default_nettype wire

// File: sv/tfn_div.sv
`default_nettype none
module tfn_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tfn_pkg::NUM_W-1:0]     num,
    input  wire logic [tfn_pkg::DEN_W-1:0]     den,
    output logic      [tfn_pkg::QUO_W-1:0]     quo
);
    localparam int N = tfn_pkg::QUO_W;

    // The quotient is known to fit in QUO_W bits, so the partial remainder
    // starts from the numerator's upper bits, which are already below den.
    logic [tfn_pkg::QUO_W-1:0]  low_reg [0:N-1];
    logic [tfn_pkg::DREM_W-1:0] rem_reg [0:N-1];
    logic [tfn_pkg::DEN_W-1:0]  den_reg [0:N-1];
    logic [tfn_pkg::QUO_W-1:0]  quo_reg [0:N-1];

    for (genvar j = 0; j < N; j++) begin : g_step
        logic [tfn_pkg::QUO_W-1:0]  low_src;
        logic [tfn_pkg::DREM_W-1:0] rem_src;
        logic [tfn_pkg::DEN_W-1:0]  den_src;
        logic [tfn_pkg::QUO_W-1:0]  quo_src;
        logic [tfn_pkg::DREM_W-1:0] rem_sh;

        if (j == 0) begin : g_first
            assign low_src = num[tfn_pkg::QUO_W-1:0];
            assign rem_src = tfn_pkg::DREM_W'(num[tfn_pkg::NUM_W-1:tfn_pkg::QUO_W]);
            assign den_src = den;
            assign quo_src = '0;
        end else begin : g_rest
            assign low_src = low_reg[j-1];
            assign rem_src = rem_reg[j-1];
            assign den_src = den_reg[j-1];
            assign quo_src = quo_reg[j-1];
        end

        assign rem_sh = {rem_src[tfn_pkg::DREM_W-2:0], low_src[tfn_pkg::QUO_W-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[j] <= {low_src[tfn_pkg::QUO_W-2:0], 1'b0};
                den_reg[j] <= den_src;
                if (rem_sh >= {1'b0, den_src})
                begin
                    rem_reg[j] <= rem_sh - {1'b0, den_src};
                    quo_reg[j] <= {quo_src[tfn_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= rem_sh;
                    quo_reg[j] <= {quo_src[tfn_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[N-1];
endmodule
`default_nettype wire

// File: sv/triangle_face_normal.sv
// Throughput: one triangle per cycle unless a stalled result waits at the output;
// every stage is registered and the whole pipeline advances together, so a
// result transfer can happen in every cycle.
// The 32-stage square root and the 15-stage dividers set the depth.
// Reset (rst_n low, asynchronous) empties the pipeline and sets min_length to 66.
`default_nettype none
module triangle_face_normal (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tfn_pkg::LEN_W-1:0]         cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] first_x,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] first_y,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] first_z,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] second_x,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] second_y,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] second_z,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] third_x,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] third_y,
    input  wire logic signed [tfn_pkg::COORD_W-1:0] third_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_x,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_y,
    output logic signed [tfn_pkg::OUT_W-1:0]       normal_z
);
    localparam int SQ_STAGES  = tfn_pkg::ROOT_W;
    localparam int DIV_STAGES = tfn_pkg::QUO_W;
    localparam int MSB        = tfn_pkg::COORD_W - 1;

    // The pipeline moves as one: it advances whenever the output register is
    // empty or its transfer completes in this cycle.
    logic en;
    logic out_valid_reg;
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;

    logic [tfn_pkg::LEN_W-1:0] min_length_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= tfn_pkg::LEN_RESET;
        else if (cfg_wr_en)
            min_length_reg <= cfg_wr_data;
    end

    // Stage valid bits for the front end (stages 1 to 8).
    logic [7:0] fv_reg;
    logic [SQ_STAGES-1:0]  sv_reg;
    logic                  dv_reg;
    logic [DIV_STAGES-1:0] vv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg        <= '0;
            sv_reg        <= '0;
            dv_reg        <= 1'b0;
            vv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg        <= {fv_reg[6:0], in_valid};
            sv_reg        <= {sv_reg[SQ_STAGES-2:0], fv_reg[7]};
            dv_reg        <= sv_reg[SQ_STAGES-1];
            vv_reg        <= {vv_reg[DIV_STAGES-2:0], dv_reg};
            out_valid_reg <= vv_reg[DIV_STAGES-1];
        end
    end

    // Stage 1: edge vectors u = b - a and v = c - a, exact at one extra bit.
    logic signed [tfn_pkg::DIFF_W-1:0] u_reg [0:2];
    logic signed [tfn_pkg::DIFF_W-1:0] v_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0] <= {second_x[MSB], second_x} - {first_x[MSB], first_x};
            u_reg[1] <= {second_y[MSB], second_y} - {first_y[MSB], first_y};
            u_reg[2] <= {second_z[MSB], second_z} - {first_z[MSB], first_z};
            v_reg[0] <= {third_x[MSB], third_x} - {first_x[MSB], first_x};
            v_reg[1] <= {third_y[MSB], third_y} - {first_y[MSB], first_y};
            v_reg[2] <= {third_z[MSB], third_z} - {first_z[MSB], first_z};
        end
    end

    // Stage 2: the six partial products of the cross product.
    logic signed [tfn_pkg::PROD_W-1:0] pa_reg [0:2];
    logic signed [tfn_pkg::PROD_W-1:0] pb_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= u_reg[1] * v_reg[2];
            pb_reg[0] <= u_reg[2] * v_reg[1];
            pa_reg[1] <= u_reg[2] * v_reg[0];
            pb_reg[1] <= u_reg[0] * v_reg[2];
            pa_reg[2] <= u_reg[0] * v_reg[1];
            pb_reg[2] <= u_reg[1] * v_reg[0];
        end
    end

    // Stage 3: cross product components.
    logic signed [tfn_pkg::CROSS_W-1:0] cr_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= {pa_reg[i][tfn_pkg::PROD_W-1], pa_reg[i]}
                           - {pb_reg[i][tfn_pkg::PROD_W-1], pb_reg[i]};
            end
        end
    end

    // Stage 4: sign and magnitude of each component.
    logic [tfn_pkg::CROSS_W-1:0] mag_reg [0:2];
    logic [2:0]                  neg4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg4_reg[i] <= cr_reg[i][tfn_pkg::CROSS_W-1];
                mag_reg[i]  <= cr_reg[i][tfn_pkg::CROSS_W-1] ? -cr_reg[i] : cr_reg[i];
            end
        end
    end

    // Stage 5: the shift that brings the largest magnitude below 2^31.
    logic [tfn_pkg::CROSS_W-1:0] any_bits;
    logic [tfn_pkg::SHIFT_W-1:0] shift_next;
    assign any_bits = mag_reg[0] | mag_reg[1] | mag_reg[2];
    always_comb
    begin
        shift_next = '0;
        for (int k = 0; k < tfn_pkg::SHIFT_SPAN; k++)
        begin
            if (any_bits[tfn_pkg::MAG_W + k])
                shift_next = tfn_pkg::SHIFT_W'(k + 1);
        end
    end

    logic [tfn_pkg::CROSS_W-1:0] mag5_reg [0:2];
    logic [2:0]                  neg5_reg;
    logic [tfn_pkg::SHIFT_W-1:0] shift_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag5_reg  <= mag_reg;
            neg5_reg  <= neg4_reg;
            shift_reg <= shift_next;
        end
    end

    // Stage 6: truncated magnitudes and the floor at the same scale.
    tfn_pkg::side_t s6_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                s6_reg.mag[i] <= tfn_pkg::MAG_W'(mag5_reg[i] >> shift_reg);
            s6_reg.neg       <= neg5_reg;
            s6_reg.floor_val <= tfn_pkg::DEN_W'(
                {min_length_reg, {tfn_pkg::FLOOR_SHIFT{1'b0}}} >> shift_reg);
        end
    end

    // Stage 7: squares.
    logic [tfn_pkg::SQ_W-1:0] sq_reg [0:2];
    tfn_pkg::side_t           s7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= s6_reg.mag[i] * s6_reg.mag[i];
            s7_reg <= s6_reg;
        end
    end

    // Stage 8: sum of squares, which fits in 64 bits.
    logic [tfn_pkg::SUM_W-1:0] sum_reg;
    tfn_pkg::side_t            s8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= tfn_pkg::SUM_W'(sq_reg[0]) + tfn_pkg::SUM_W'(sq_reg[1])
                     + tfn_pkg::SUM_W'(sq_reg[2]);
            s8_reg  <= s7_reg;
        end
    end

    // Square root, with the side values delayed to match.
    logic [tfn_pkg::ROOT_W-1:0] root;
    tfn_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    tfn_pkg::side_t side_reg [0:SQ_STAGES-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s8_reg;
            for (int k = 1; k < SQ_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // Divisor stage: D = max(length, floor, 1), numerators with half-D rounding.
    tfn_pkg::side_t              sd;
    logic [tfn_pkg::DEN_W-1:0]   den_next;
    assign sd = side_reg[SQ_STAGES-1];
    always_comb
    begin
        den_next = (root > sd.floor_val) ? root : sd.floor_val;
        if (den_next == '0)
            den_next = tfn_pkg::DEN_W'(1);
    end

    logic [tfn_pkg::DEN_W-1:0] den_reg;
    logic [tfn_pkg::NUM_W-1:0] num_reg [0:2];
    logic [2:0]                negd_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_next;
            negd_reg <= sd.neg;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= tfn_pkg::NUM_W'({sd.mag[i], {tfn_pkg::FRAC_W{1'b0}}})
                            + tfn_pkg::NUM_W'(den_next >> 1);
            end
        end
    end

    // Three dividers share the divisor.
    logic [tfn_pkg::QUO_W-1:0] quo [0:2];
    for (genvar i = 0; i < 3; i++) begin : g_div
        tfn_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    logic [2:0] negq_reg [0:DIV_STAGES-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negq_reg[0] <= negd_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                negq_reg[k] <= negq_reg[k-1];
        end
    end

    // Output register: cap at one unit and restore the sign.
    logic [tfn_pkg::OUT_W-1:0] res_reg [0:2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [tfn_pkg::OUT_W-1:0] q;
                q = tfn_pkg::OUT_W'((quo[i] > tfn_pkg::Q_CAP) ? tfn_pkg::Q_CAP : quo[i]);
                res_reg[i] <= negq_reg[DIV_STAGES-1][i] ? -q : q;
            end
        end
    end

    assign normal_x = res_reg[0];
    assign normal_y = res_reg[1];
    assign normal_z = res_reg[2];
endmodule
`default_nettype wire

// File: sv/tfn_checker.sv
`default_nettype none
module tfn_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [tfn_pkg::OUT_W-1:0]     normal_x,
    input wire logic [tfn_pkg::OUT_W-1:0]     normal_y,
    input wire logic [tfn_pkg::OUT_W-1:0]     normal_z
);
    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(normal_x) && $stable(normal_y)
                                   && $stable(normal_z))
        else $error("result changed while stalled");

    // Input is held back only when a finished result is waiting.
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // Components never exceed one unit in magnitude.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(normal_x) <= 16384 && $signed(normal_x) >= -16384
                    && $signed(normal_y) <= 16384 && $signed(normal_y) >= -16384
                    && $signed(normal_z) <= 16384 && $signed(normal_z) >= -16384))
        else $error("normal component out of range");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z)
);
`default_nettype wire
